// ===== hdl/mat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_pkg
// Shared constants, register indexes and types for the 3x3 adaptive mean
// threshold block.
// ----------------------------------------------------------------------------
package mat_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Field and register widths.
  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int OFS_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Counter widths follow from the frame limits.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Window and arithmetic sizes.
  localparam int WIN_SIZE    = 9;
  localparam int SUM_W       = 12;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 13;
  // ceil(2^16 / 9); exact floor division for every 12-bit window sum.
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int THR_W  = PIX_W + 1;

  // Result queue and pipeline occupancy.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  localparam int OCC_W      = FIFO_CNT_W + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFFSET = 2'd2;

  // Register reset values.
  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH      = 11'd640;
  localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT     = 13'd480;
  localparam logic [OFS_W-1:0] RST_THRESHOLD_OFFSET = 8'd0;

  // Output pixel codes.
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  // One accepted pixel with its position-derived flags.
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [COL_W-1:0] col;
    logic             produce;
    logic             last;
  } scan_t;

  // Flags that follow a pixel down the arithmetic pipeline.
  typedef struct packed {
    logic produce;
    logic last;
  } tag_t;

  // 3x3 neighborhood, index row*3 + col, row 0 oldest, col 2 newest.
  typedef logic [WIN_SIZE-1:0][PIX_W-1:0] window_t;

  // One binarized result.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } result_t;

endpackage

// ===== hdl/mat_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_scan
// Raster position counters. Latches the frame size at the first pixel of
// each frame and tags every accepted pixel with its column and flags.
// ----------------------------------------------------------------------------
module mat_scan import mat_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [PIX_W-1:0] px,
  input  logic [FW_W-1:0] cfg_width,
  input  logic [FH_W-1:0] cfg_height,
  output scan_t           item
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [FW_W-1:0]  act_w_r, act_w;
  logic [FH_W-1:0]  act_h_r, act_h;
  logic             first;
  logic [FW_W-1:0]  col_inc;
  logic [FH_W-1:0]  row_inc;

  // Clamp the configured sizes to the supported range.
  function automatic logic [FW_W-1:0] clamp_w(input logic [FW_W-1:0] v);
    logic [FW_W-1:0] r;
    r = v;
    if (v < FW_W'(3)) r = FW_W'(3);
    else if (v > FW_W'(MAX_WIDTH)) r = FW_W'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [FH_W-1:0] clamp_h(input logic [FH_W-1:0] v);
    logic [FH_W-1:0] r;
    r = v;
    if (v < FH_W'(3)) r = FH_W'(3);
    else if (v > FH_W'(MAX_HEIGHT)) r = FH_W'(MAX_HEIGHT);
    return r;
  endfunction

  // The frame size is sampled when the first pixel of a frame arrives.
  always_comb begin
    first   = (col_r == '0) && (row_r == '0);
    act_w   = first ? clamp_w(cfg_width) : act_w_r;
    act_h   = first ? clamp_h(cfg_height) : act_h_r;
    col_inc = {{(FW_W-COL_W){1'b0}}, col_r} + FW_W'(1);
    row_inc = {{(FH_W-ROW_W){1'b0}}, row_r} + FH_W'(1);

    item.px      = px;
    item.col     = col_r;
    item.produce = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
    item.last    = (row_inc == act_h) && (col_inc == act_w);

    // Advance the raster position, wrapping at line and frame ends.
    if (col_inc >= act_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= act_h) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      act_w_r <= clamp_w(RST_FRAME_WIDTH);
      act_h_r <= clamp_h(RST_FRAME_HEIGHT);
    end else if (accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      act_w_r <= act_w;
      act_h_r <= act_h;
    end
  end

  // The column never reaches the latched line width.
  assert property (@(posedge clk) disable iff (!rst_n)
    {{(FW_W-COL_W){1'b0}}, col_r} < act_w_r || first)
    else $error("column counter beyond line width");

endmodule

// ===== hdl/mat_linebuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_linebuf
// Line memory holding the two previous lines as one 16-bit word per
// column, plus the 3x3 window registers. Each pixel reads its column,
// then writes back the shifted pair in the following cycle.
// ----------------------------------------------------------------------------
module mat_linebuf import mat_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  scan_t   item,
  output logic    v1,
  output logic    v2,
  output tag_t    tag2,
  output window_t win
);

  // Word layout: upper byte is two lines up, lower byte is one line up.
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;
  logic               v1_r, v2_r;
  scan_t              s1_r;
  tag_t               tag2_r;
  window_t            win_r, win_nxt;
  logic [PIX_W-1:0]   up1, up2;

  // Read the column of the incoming pixel.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[item.col];
    end
  end

  // Write back the column in the cycle after its read: old line one moves to line two.
  always_ff @(posedge clk) begin
    if (v1_r) begin
      mem[s1_r.col] <= {rd_data_r[PIX_W-1:0], s1_r.px};
    end
  end

  // Window shift with the new column entering on the right.
  always_comb begin
    up2     = rd_data_r[2*PIX_W-1:PIX_W];
    up1     = rd_data_r[PIX_W-1:0];
    win_nxt = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[2] = up2;
    win_nxt[5] = up1;
    win_nxt[8] = s1_r.px;
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= item;
    end
    if (v1_r) begin
      win_r          <= win_nxt;
      tag2_r.produce <= s1_r.produce;
      tag2_r.last    <= s1_r.last;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  assign v1   = v1_r;
  assign v2   = v2_r;
  assign tag2 = tag2_r;
  assign win  = win_r;

  // A read never targets the word being written back in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && v1_r |-> item.col != s1_r.col)
    else $error("line memory read and write collide");

  // The window stage is only ever fed by the read stage in the cycle before.
  assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("window stage valid without a read");

endmodule

// ===== hdl/mat_thresh.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_thresh
// Window sum, division by nine through a reciprocal multiply, and the
// comparison of the center pixel against mean plus offset.
// ----------------------------------------------------------------------------
module mat_thresh import mat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v2,
  input  tag_t             tag2,
  input  window_t          win,
  input  logic [OFS_W-1:0] offset,
  output logic             v3,
  output logic             v4,
  output logic             push,
  output result_t          result
);

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_r;
  logic [PIX_W-1:0]  center3_r, center4_r;
  tag_t              tag3_r, tag4_r;
  logic              v3_r, v4_r;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  mean_r;
  logic [THR_W-1:0]  thr;

  // Sum of the nine window pixels.
  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      sum = sum + SUM_W'(win[i]);
    end
  end

  // Floor of sum / 9 by reciprocal multiplication.
  assign prod = PROD_W'(sum_r) * PROD_W'(RECIP_9);

  always_ff @(posedge clk) begin
    if (v2) begin
      sum_r     <= sum;
      center3_r <= win[4];
      tag3_r    <= tag2;
    end
    if (v3_r) begin
      mean_r    <= prod[RECIP_SHIFT +: PIX_W];
      center4_r <= center3_r;
      tag4_r    <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= v2;
      v4_r <= v3_r;
    end
  end

  // Full-width threshold, so an offset pushing it past 255 gives black.
  always_comb begin
    thr          = {1'b0, mean_r} + {1'b0, offset};
    result.pixel = ({1'b0, center4_r} < thr) ? PIX_BLACK : PIX_WHITE;
    result.last  = tag4_r.last;
    push         = v4_r && tag4_r.produce;
  end

  assign v3 = v3_r;
  assign v4 = v4_r;

  // Each stage is fed only from the one before it.
  assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> $past(v3_r))
    else $error("threshold stage valid without a product");

endmodule

// ===== hdl/mat_ofifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_ofifo
// Small result queue that decouples the fixed-latency pipeline from the
// output handshake.
// ----------------------------------------------------------------------------
module mat_ofifo import mat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  result_t               din,
  input  logic                  pop_ready,
  output logic                  dout_valid,
  output result_t               dout,
  output logic [FIFO_CNT_W-1:0] count
);

  result_t               q_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  pop;

  assign dout_valid = (cnt_r != '0);
  assign dout       = q_r[rd_ptr_r];
  assign pop        = dout_valid && pop_ready;
  assign count      = cnt_r;

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + FIFO_CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - FIFO_CNT_W'(1);
    end
  end

  // Input credit must keep the queue from ever overflowing.
  assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

endmodule

// ===== hdl/mean_3x3_adaptive_threshold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_3x3_adaptive_threshold
// Binarizes an 8-bit grayscale stream against the local 3x3 mean plus a
// programmable offset. Pixels enter in raster order, one per clock at full
// rate; each one costs one read and one write-back of a single 16-bit word
// in the line memory, which holds the two previous lines side by side, and
// that memory port sets the rate of one pixel per cycle. A result passes
// the read, window, sum and mean registers. Only interior pixels give a
// result, so a frame of H lines by W pixels yields (H-2) by (W-2) results,
// the last one flagged on out_tlast. Width and height are clamped to
// 3..1024 and 3..4096 and sampled when the first pixel of a frame arrives.
// A short result queue lets input continue while the output stalls; input
// is held off only when that queue and the pipeline together are full.
// Configuration must be written while the stream is idle (not enforced).
// ----------------------------------------------------------------------------
module mean_3x3_adaptive_threshold import mat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] pixel_in
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] pixel_out
  output logic                  out_tlast,  // frame_done
  // Configuration write port.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [FW_W-1:0]       frame_width_r;
  logic [FH_W-1:0]       frame_height_r;
  logic [OFS_W-1:0]      threshold_offset_r;
  logic                  accept;
  scan_t                 item;
  logic                  v1, v2, v3, v4;
  tag_t                  tag2;
  window_t               win;
  logic                  push;
  result_t               result, head;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [OCC_W-1:0]      occupancy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r      <= RST_FRAME_WIDTH;
      frame_height_r     <= RST_FRAME_HEIGHT;
      threshold_offset_r <= RST_THRESHOLD_OFFSET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:      frame_width_r      <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT:     frame_height_r     <= cfg_wdata[FH_W-1:0];
        REG_THRESHOLD_OFFSET: threshold_offset_r <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Every request in flight or queued holds one queue slot.
  assign occupancy = OCC_W'(v1) + OCC_W'(v2) + OCC_W'(v3) + OCC_W'(v4)
                   + OCC_W'(fifo_count);
  assign in_tready = (occupancy < OCC_W'(FIFO_DEPTH));
  assign accept    = in_tvalid && in_tready;

  mat_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .px         (in_tdata),
    .cfg_width  (frame_width_r),
    .cfg_height (frame_height_r),
    .item       (item)
  );

  mat_linebuf u_linebuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .v1     (v1),
    .v2     (v2),
    .tag2   (tag2),
    .win    (win)
  );

  mat_thresh u_thresh (
    .clk    (clk),
    .rst_n  (rst_n),
    .v2     (v2),
    .tag2   (tag2),
    .win    (win),
    .offset (threshold_offset_r),
    .v3     (v3),
    .v4     (v4),
    .push   (push),
    .result (result)
  );

  mat_ofifo u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .din        (result),
    .pop_ready  (out_tready),
    .dout_valid (out_tvalid),
    .dout       (head),
    .count      (fifo_count)
  );

  assign out_tdata = head.pixel;
  assign out_tlast = head.last;

  // Credit accounting never admits more requests than queue slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= OCC_W'(FIFO_DEPTH))
    else $error("pipeline occupancy exceeds queue depth");

endmodule

// ===== sim/mean_3x3_adaptive_threshold_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_3x3_adaptive_threshold_checker
// Passive scoreboard for the 3x3 adaptive mean threshold block. It follows
// every configuration write and every accepted pixel request. For each pixel
// it rebuilds the line memories and the 3x3 neighborhood, and for interior
// pixels queues the binarized pixel and end-of-frame flag the block must
// produce. Each accepted result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module mean_3x3_adaptive_threshold_checker import mat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] pixel_in
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,  // [7:0] pixel_out
  input  logic                  out_tlast,  // frame_done
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);

  // Predicted results waiting for the block, oldest first.
  result_t          binarized_q[$];

  // Shadow of the line memories, the neighborhood and the scan position.
  logic [PIX_W-1:0] line_prev  [MAX_WIDTH];
  logic [PIX_W-1:0] line_prev2 [MAX_WIDTH];
  window_t          nbhd;
  int               col_pos;
  int               row_pos;

  // Shadow of the registers and of the sizes latched at frame start.
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  logic [OFS_W-1:0] offset_reg;
  int               frame_w;
  int               frame_h;
  int               error_total;

  function automatic int clamp_dim(int v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the raster scan by one pixel and queues the binarized result
  // that an interior pixel yields.
  task automatic binarize_pixel(input logic [PIX_W-1:0] px);
    logic [PIX_W-1:0] above2;
    logic [PIX_W-1:0] above1;
    logic [SUM_W-1:0] sum;
    logic [THR_W-1:0] thr;
    result_t          res;
    // Sizes only take effect on the first pixel of a frame.
    if (col_pos == 0 && row_pos == 0) begin
      frame_w = clamp_dim(int'(width_reg), MAX_WIDTH);
      frame_h = clamp_dim(int'(height_reg), MAX_HEIGHT);
    end
    above2 = line_prev2[col_pos];
    above1 = line_prev[col_pos];
    for (int r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = above2;
    nbhd[5] = above1;
    nbhd[8] = px;
    line_prev2[col_pos] = above1;
    line_prev[col_pos]  = px;

    // Interior pixel: compare the center with the floored mean plus offset.
    // The threshold keeps its ninth bit, so it can exceed full white.
    if (row_pos >= 2 && col_pos >= 2) begin
      sum = '0;
      for (int i = 0; i < WIN_SIZE; i++) sum += SUM_W'(nbhd[i]);
      thr = THR_W'(sum / WIN_SIZE) + THR_W'(offset_reg);
      res.pixel = (THR_W'(nbhd[4]) < thr) ? PIX_BLACK : PIX_WHITE;
      res.last  = (row_pos + 1 == frame_h) && (col_pos + 1 == frame_w);
      binarized_q.push_back(res);
    end

    // Step the scan position and wrap at the end of a line and of a frame.
    if (col_pos + 1 >= frame_w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= frame_h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // Follow the channels on every rising edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      binarized_q.delete();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_prev[i]  = '0;
        line_prev2[i] = '0;
      end
      nbhd        = '0;
      col_pos     = 0;
      row_pos     = 0;
      width_reg   = RST_FRAME_WIDTH;
      height_reg  = RST_FRAME_HEIGHT;
      offset_reg  = RST_THRESHOLD_OFFSET;
      frame_w     = clamp_dim(int'(RST_FRAME_WIDTH), MAX_WIDTH);
      frame_h     = clamp_dim(int'(RST_FRAME_HEIGHT), MAX_HEIGHT);
      error_total = 0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      // Register writes; unused indexes change nothing.
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:      width_reg  = cfg_wdata[FW_W-1:0];
          REG_FRAME_HEIGHT:     height_reg = cfg_wdata[FH_W-1:0];
          REG_THRESHOLD_OFFSET: offset_reg = cfg_wdata[OFS_W-1:0];
          default: ;
        endcase
      end

      // Compare an accepted result with the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (binarized_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got pixel %0d last %0b",
                   $time, out_tdata, out_tlast);
          error_total++;
        end else begin
          want = binarized_q.pop_front();
          if (out_tdata !== want.pixel) begin
            $display("%0t: pixel_out mismatch: expected %0d, got %0d",
                     $time, want.pixel, out_tdata);
            error_total++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: frame_done mismatch: expected %0b, got %0b",
                     $time, want.last, out_tlast);
            error_total++;
          end
        end
      end

      if (in_tvalid && in_tready) binarize_pixel(in_tdata);

      mismatches  <= error_total;
      outstanding <= binarized_q.size();
    end
  end

endmodule

// ===== sim/mean_3x3_adaptive_threshold_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_3x3_adaptive_threshold_tb
// Drives pixel frames into the 3x3 adaptive mean threshold block and gives
// the verdict. A short directed part covers dark and flat neighborhoods, a
// threshold above full white and back-to-back frames. Then come frames whose
// sizes are reached through masking and clamping, one of them with a long
// receiver hold-off, and random frames of small sizes and varied texture,
// with sizes changed both between frames and in the middle of a frame,
// under several sender and receiver stall patterns. A separate checker
// predicts and compares all results.
// ----------------------------------------------------------------------------
module mean_3x3_adaptive_threshold_tb;
  import mat_pkg::*;

  localparam int RESET_CYCLES    = 6;
  localparam int LAT_PAUSE       = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 4000;
  localparam int PHASE_ITEMS     = 240;
  localparam int NUM_PHASES      = 4;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Picture content of a random frame.
  typedef enum int {TEX_NOISE, TEX_FLAT_JITTER, TEX_BINARY, TEX_FLAT} texture_t;

  // Idle percentages per phase: none, sender, receiver, both.
  localparam int SEND_IDLE_TAB[NUM_PHASES] = '{0, 48, 0, 12};
  localparam int RECV_STALL_TAB[NUM_PHASES] = '{0, 0, 48, 12};

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [7:0] pixel_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // [7:0] pixel_out
  logic                  out_tlast;         // frame_done
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int mismatches;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_req   = 1'b0;
  int quiet_cycles   = 0;
  int pixels_sent    = 0;

  // Register values as last written, for frame length bookkeeping.
  logic [FW_W-1:0] width_shadow  = RST_FRAME_WIDTH;
  logic [FH_W-1:0] height_shadow = RST_FRAME_HEIGHT;

  always #6 clk = ~clk;

  mean_3x3_adaptive_threshold u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  mean_3x3_adaptive_threshold_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Result receiver: random stalls, plus a long hold-off when requested.
  initial forever begin
    @(posedge clk);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_tready <= 1'b0;
      repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One register write; the enable is driven low again before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_FRAME_WIDTH) width_shadow = val[FW_W-1:0];
    if (idx == REG_FRAME_HEIGHT) height_shadow = val[FH_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one pixel after a random gap and waits until it is accepted.
  task automatic send_pixel(input logic [7:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // Stops sending until every predicted result has arrived, then lets the
  // pipeline settle for border pixels that give no result.
  task automatic idle_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (LAT_PAUSE) @(posedge clk);
  endtask

  // Random frame size (sometimes below the minimum) and threshold offset.
  // Bits above the width and offset registers' widths are filled at random.
  task automatic reconfigure();
    logic [FW_W-1:0]  w;
    logic [FH_W-1:0]  h;
    logic [OFS_W-1:0] ofs;
    w = ($urandom_range(7) == 0) ? FW_W'($urandom_range(2)) : FW_W'(3 + $urandom_range(9));
    h = ($urandom_range(7) == 0) ? FH_W'($urandom_range(2)) : FH_W'(3 + $urandom_range(5));
    case ($urandom_range(3))
      0:       ofs = '0;
      1:       ofs = '1;
      2:       ofs = OFS_W'($urandom_range(16));
      default: ofs = OFS_W'($urandom);
    endcase
    write_reg(REG_FRAME_WIDTH, {2'($urandom), w});
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_THRESHOLD_OFFSET, {5'($urandom), ofs});
  endtask

  // Sends one whole frame at the sizes now in the registers. Optionally the
  // sizes are rewritten in the middle of the frame, or the receiver is held
  // off three quarters of the way through.
  task automatic send_frame(input texture_t tex, input bit pause_mid,
                            input bit hold_mid);
    int         w;
    int         h;
    int         n;
    int         pause_at;
    int         v;
    logic [7:0] base;
    w = (width_shadow < 3) ? 3 : (width_shadow > MAX_WIDTH) ? MAX_WIDTH : width_shadow;
    h = (height_shadow < 3) ? 3 : (height_shadow > MAX_HEIGHT) ? MAX_HEIGHT : height_shadow;
    n = w * h;
    pause_at = pause_mid ? 1 + $urandom_range(n - 2) : -1;
    base = 8'($urandom);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) begin
        idle_until_drained();
        reconfigure();
      end
      if (hold_mid && i == n * 3 / 4) hold_off_req = 1'b1;
      case (tex)
        TEX_NOISE:       v = $urandom_range(255);
        TEX_FLAT_JITTER: v = int'(base) + int'($urandom_range(16)) - 8;
        TEX_BINARY:      v = $urandom_range(1) ? 255 : 0;
        default:         v = base;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      send_pixel(8'(v));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int  phase_start;
    bit  first;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame: a dark center in a white field, then an all-black
    // frame straight after it, where the center equals its mean.
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_THRESHOLD_OFFSET, 13'd0);
    write_reg(REG_UNUSED, '1);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? PIX_BLACK : PIX_WHITE);
    for (int i = 0; i < 9; i++) send_pixel(PIX_BLACK);

    // Largest offset pushes the threshold above full white.
    idle_until_drained();
    write_reg(REG_THRESHOLD_OFFSET, 13'd255);
    for (int i = 0; i < 9; i++) send_pixel(PIX_WHITE);

    // Width of 64 reached through masking of the upper data bits, height
    // clamped up from 2, with a long receiver hold-off while the last line
    // streams in.
    idle_until_drained();
    write_reg(REG_FRAME_WIDTH, 13'h1840);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    write_reg(REG_THRESHOLD_OFFSET, 13'd4);
    send_frame(TEX_NOISE, 1'b0, 1'b1);

    // Narrowest frame, both sizes clamped up from zero.
    idle_until_drained();
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    write_reg(REG_THRESHOLD_OFFSET, 13'd1);
    send_frame(TEX_FLAT_JITTER, 1'b0, 1'b0);

    // Random frames under each stall pattern; the first frame of a phase
    // has its sizes rewritten midway.
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = SEND_IDLE_TAB[p];
      recv_stall_pct = RECV_STALL_TAB[p];
      phase_start    = pixels_sent;
      first          = 1'b1;
      while (pixels_sent - phase_start < PHASE_ITEMS) begin
        if (first || $urandom_range(1)) begin
          idle_until_drained();
          reconfigure();
        end
        send_frame(texture_t'($urandom_range(3)), first, 1'b0);
        first = 1'b0;
      end
    end

    idle_until_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mat_pkg.sv
hdl/mat_scan.sv
hdl/mat_linebuf.sv
hdl/mat_thresh.sv
hdl/mat_ofifo.sv
hdl/mean_3x3_adaptive_threshold.sv
sim/mean_3x3_adaptive_threshold_checker.sv
sim/mean_3x3_adaptive_threshold_tb.sv
